@@ rtl/opc_pkg.sv @@
// Package for obstacle point clustering: widths, register indexes and limits.
// No dependencies.
`timescale 1ns / 1ps
package opc_pkg;
    localparam int COORD_W = 13;
    localparam int CNT_W   = 7;
    localparam int RAD_W   = 10;
    localparam int MINM_W  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int ROBOT_CLEAR_SQ = 10000;
    localparam int RESULT_CAP = 64;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINMEM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R1X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R1Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R2X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R2Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_R3X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_R3Y = 3'd7;
endpackage

@@ rtl/obstacle_point_clustering_core.sv @@
// Obstacle point clustering core. Points load one per cycle while tready is high; the beat
// with tlast starts clustering. Each pair check uses one shared squared-distance unit
// in three steps (read, square, compare), and each centroid then runs SW (20 for 64
// points) divide steps. Each centroid waits in a holding register so the frame's
// final beat carries tlast. Input tready is low while clustering or results are
// pending. Reset (i_rst_n low, synchronous) clears control state and loads the
// register defaults.
`timescale 1ns / 1ps
module obstacle_point_clustering_core
    import opc_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // point_x[12:0], point_y[25:13], zero
    input  logic                 s_axis_tlast,  // frame_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,  // centroid_x, centroid_y, member_count, zero
    output logic                 m_axis_tuser,  // no_cluster
    output logic                 m_axis_tlast,  // last_result
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = COORD_W + NW;

    typedef enum logic [3:0] {
        S_LOAD, S_SEED, S_ROB_RD, S_ROB_SQ, S_ROB_CMP, S_JSCAN, S_K_RD, S_K_SQ,
        S_K_CMP, S_EVAL, S_DIV, S_OUT, S_EMPTY
    } t_state;

    t_state r_state;
    logic signed [COORD_W-1:0] r_mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] r_mem_y [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_visited, r_group;
    logic [NW-1:0] r_n, r_i, r_j, r_k;
    logic [1:0] r_rob;
    logic signed [SW-1:0] r_sum_x, r_sum_y;
    logic [NW-1:0] r_cnt;
    logic [6:0] r_nres;
    logic [39:0] r_pdata;
    logic r_pvalid;
    logic [RAD_W-1:0] r_radius;
    logic [MINM_W-1:0] r_minm;
    logic signed [COORD_W-1:0] r_rx [3];
    logic signed [COORD_W-1:0] r_ry [3];
    // shared distance unit
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic [2*COORD_W+1:0] r_d2;
    logic signed [COORD_W:0] w_dx, w_dy;
    // serial divider
    logic [SW-1:0] r_qx, r_qy, r_remx, r_remy;
    logic r_negx, r_negy;
    logic [$clog2(SW+1)-1:0] r_dstep;
    logic [39:0] r_odata;
    logic r_ouser, r_olast, r_ovalid;

    logic w_in_acc;
    logic [SW:0] w_tx, w_ty;
    logic [2*RAD_W-1:0] w_r2;

    assign w_dx = {r_ax[COORD_W-1], r_ax} - {r_bx[COORD_W-1], r_bx};
    assign w_dy = {r_ay[COORD_W-1], r_ay} - {r_by[COORD_W-1], r_by};
    assign w_r2 = r_radius * r_radius;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_tx = {r_remx, r_qx[SW-1]} - {{(SW-NW+1){1'b0}}, r_cnt};
    assign w_ty = {r_remy, r_qy[SW-1]} - {{(SW-NW+1){1'b0}}, r_cnt};

    assign s_axis_tready = (r_state == S_LOAD) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_n < NW'(MAX_POINTS))) begin
            r_mem_x[r_n[IW-1:0]] <= s_axis_tdata[12:0];
            r_mem_y[r_n[IW-1:0]] <= s_axis_tdata[25:13];
        end
        if (r_state == S_ROB_RD || r_state == S_K_RD) begin
            r_ax <= r_mem_x[(r_state == S_ROB_RD) ? r_i[IW-1:0] : r_k[IW-1:0]];
            r_ay <= r_mem_y[(r_state == S_ROB_RD) ? r_i[IW-1:0] : r_k[IW-1:0]];
            r_bx <= (r_state == S_ROB_RD) ? r_rx[r_rob] : r_mem_x[r_j[IW-1:0]];
            r_by <= (r_state == S_ROB_RD) ? r_ry[r_rob] : r_mem_y[r_j[IW-1:0]];
        end
        r_d2 <= (2*COORD_W+2)'(w_dx * w_dx) + (2*COORD_W+2)'(w_dy * w_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n <= '0;
            r_ovalid <= 1'b0;
            r_pvalid <= 1'b0;
            r_radius <= RAD_W'(50);
            r_minm <= MINM_W'(2);
            for (int q = 0; q < 3; q++) begin
                r_rx[q] <= '0;
                r_ry[q] <= '0;
            end
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                    REG_MINMEM: r_minm <= i_cfg_data[MINM_W-1:0];
                    REG_R1X: r_rx[0] <= i_cfg_data;
                    REG_R1Y: r_ry[0] <= i_cfg_data;
                    REG_R2X: r_rx[1] <= i_cfg_data;
                    REG_R2Y: r_ry[1] <= i_cfg_data;
                    REG_R3X: r_rx[2] <= i_cfg_data;
                    REG_R3Y: r_ry[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_LOAD: if (w_in_acc) begin
                    if (r_n < NW'(MAX_POINTS)) r_n <= r_n + 1'b1;
                    if (s_axis_tlast) begin
                        r_visited <= '0;
                        r_i <= '0;
                        r_nres <= '0;
                        r_pvalid <= 1'b0;
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    if (r_i >= r_n) r_state <= S_EMPTY;
                    else if (r_visited[r_i[IW-1:0]]) r_i <= r_i + 1'b1;
                    else begin
                        r_rob <= '0;
                        r_state <= S_ROB_RD;
                    end
                end
                S_ROB_RD: begin
                    // skip absent poses
                    if (r_rx[r_rob] <= 0 && r_ry[r_rob] <= 0) begin
                        if (r_rob == 2'd2) begin
                            r_group <= MAX_POINTS'(1) << r_i[IW-1:0];
                            r_sum_x <= '0;
                            r_sum_y <= '0;
                            r_cnt <= '0;
                            r_j <= '0;
                            r_state <= S_JSCAN;
                        end else r_rob <= r_rob + 1'b1;
                    end else r_state <= S_ROB_SQ;
                end
                S_ROB_SQ: r_state <= S_ROB_CMP;
                S_ROB_CMP: begin
                    if (r_d2 < (2*COORD_W+2)'(ROBOT_CLEAR_SQ)) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SEED;
                    end else if (r_rob == 2'd2) begin
                        r_group <= MAX_POINTS'(1) << r_i[IW-1:0];
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_cnt <= '0;
                        r_j <= '0;
                        r_state <= S_JSCAN;
                    end else begin
                        r_rob <= r_rob + 1'b1;
                        r_state <= S_ROB_RD;
                    end
                end
                S_JSCAN: begin
                    if (r_j >= r_n) r_state <= S_EVAL;
                    else if (r_visited[r_j[IW-1:0]]) r_j <= r_j + 1'b1;
                    else begin
                        r_k <= '0;
                        r_state <= S_K_RD;
                    end
                end
                S_K_RD: begin
                    // advance k to next group member
                    if (r_k >= r_n) begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_JSCAN;
                    end else if (!r_group[r_k[IW-1:0]]) r_k <= r_k + 1'b1;
                    else r_state <= S_K_SQ;
                end
                S_K_SQ: r_state <= S_K_CMP;
                S_K_CMP: begin
                    if (r_d2 < (2*COORD_W+2)'(w_r2)) begin
                        r_sum_x <= r_sum_x + SW'(r_bx);
                        r_sum_y <= r_sum_y + SW'(r_by);
                        r_cnt <= r_cnt + 1'b1;
                        r_visited[r_j[IW-1:0]] <= 1'b1;
                        r_group[r_j[IW-1:0]] <= 1'b1;
                        r_j <= r_j + 1'b1;
                        r_state <= S_JSCAN;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_K_RD;
                    end
                end
                S_EVAL: begin
                    if ({{NW{1'b0}}, r_minm} < {{MINM_W{1'b0}}, r_cnt} &&
                        r_nres < 7'(RESULT_CAP)) begin
                        r_negx <= r_sum_x[SW-1];
                        r_negy <= r_sum_y[SW-1];
                        r_qx <= r_sum_x[SW-1] ? -r_sum_x : r_sum_x;
                        r_qy <= r_sum_y[SW-1] ? -r_sum_y : r_sum_y;
                        r_remx <= '0;
                        r_remy <= '0;
                        r_dstep <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SEED;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle, restoring
                    if (!w_tx[SW]) begin
                        r_remx <= w_tx[SW-1:0];
                        r_qx <= {r_qx[SW-2:0], 1'b1};
                    end else begin
                        r_remx <= {r_remx[SW-2:0], r_qx[SW-1]};
                        r_qx <= {r_qx[SW-2:0], 1'b0};
                    end
                    if (!w_ty[SW]) begin
                        r_remy <= w_ty[SW-1:0];
                        r_qy <= {r_qy[SW-2:0], 1'b1};
                    end else begin
                        r_remy <= {r_remy[SW-2:0], r_qy[SW-1]};
                        r_qy <= {r_qy[SW-2:0], 1'b0};
                    end
                    r_dstep <= r_dstep + 1'b1;
                    if (r_dstep == ($bits(r_dstep))'(SW-1)) r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    // release the held centroid, hold the new one
                    if (r_pvalid) begin
                        r_odata <= r_pdata;
                        r_ouser <= 1'b0;
                        r_olast <= 1'b0;
                        r_ovalid <= 1'b1;
                    end
                    r_pdata <= {7'd0, 7'(r_cnt),
                                r_negy ? -r_qy[COORD_W-1:0] : r_qy[COORD_W-1:0],
                                r_negx ? -r_qx[COORD_W-1:0] : r_qx[COORD_W-1:0]};
                    r_pvalid <= 1'b1;
                    r_nres <= r_nres + 1'b1;
                    r_i <= r_i + 1'b1;
                    r_state <= (r_nres == 7'(RESULT_CAP-1)) ? S_EMPTY : S_SEED;
                end
                S_EMPTY: if (!r_ovalid) begin
                    // send the held centroid as the final beat, or the empty marker
                    r_odata <= r_pvalid ? r_pdata : '0;
                    r_ouser <= !r_pvalid;
                    r_olast <= 1'b1;
                    r_ovalid <= 1'b1;
                    r_pvalid <= 1'b0;
                    r_n <= '0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

@@ rtl/opc_checker.sv @@
// Port checker for the clustering core, bound into the core module.
// Depends on opc_pkg.
`timescale 1ns / 1ps
module opc_checker
    import opc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic m_axis_tuser,
    input logic m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped while stalled");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("empty result malformed");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");
endmodule

bind obstacle_point_clustering_core opc_checker u_opc_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking bench for obstacle_point_clustering_core: sends point frames and
// compares every centroid beat against an in-bench clustering predictor.
// Depends on opc_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
    import opc_pkg::*;

    localparam int NPTS  = 64;
    localparam int LIMIT = 20_000_000;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [CNT_W-1:0]          cnt;
        logic                      empty;
        logic                      lst;
    } t_centroid;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    obstacle_point_clustering_core #(.MAX_POINTS(NPTS)) dut (.*);

    // predictor state
    int        pt_x [NPTS];
    int        pt_y [NPTS];
    int        pts_held;
    int        radius;
    int        min_mem;
    int        pose_x [3];
    int        pose_y [3];
    t_centroid centroid_q [$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  steady = 1'b0;     // no random idling on either side while set
    bit  hold_req = 1'b0;   // ask the receiver for a long hold-off

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[obstacle_point_clustering_core] ERROR");
            $finish;
        end
    end

    function automatic int dist_sq(int ax, int ay, int bx, int by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic bit by_teammate(int i);
        bit hit = 1'b0;
        for (int r = 0; r < 3; r++) begin
            if (!(pose_x[r] <= 0 && pose_y[r] <= 0) &&
                dist_sq(pt_x[i], pt_y[i], pose_x[r], pose_y[r]) < ROBOT_CLEAR_SQ)
                hit = 1'b1;
        end
        return hit;
    endfunction

    // append one expected beat
    task automatic queue_result(t_centroid c);
        centroid_q.insert(centroid_q.size(), c);
    endtask

    // Run the greedy clustering over the held points and queue the centroids, or the empty marker.
    task automatic cluster_frame();
        bit        visited [NPTS];
        bit        grouped [NPTS];
        int        n;
        int        r2;
        int        sx;
        int        sy;
        int        joined;
        int        emitted;
        t_centroid c;
        n = pts_held;
        r2 = radius * radius;
        emitted = 0;
        foreach (visited[i]) visited[i] = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (visited[i] || by_teammate(i)) continue;
            foreach (grouped[g]) grouped[g] = 1'b0;
            grouped[i] = 1'b1;
            sx = 0; sy = 0; joined = 0;
            for (int j = 0; j < n; j++) begin
                if (visited[j]) continue;
                for (int k = 0; k < n; k++) begin
                    if (grouped[k] && dist_sq(pt_x[k], pt_y[k], pt_x[j], pt_y[j]) < r2) begin
                        sx += pt_x[j]; sy += pt_y[j]; joined++;
                        visited[j] = 1'b1; grouped[j] = 1'b1;
                        break;
                    end
                end
            end
            if (joined > min_mem && emitted < RESULT_CAP) begin
                c.cx = COORD_W'(sx / joined);
                c.cy = COORD_W'(sy / joined);
                c.cnt = CNT_W'(joined);
                c.empty = 1'b0;
                c.lst = 1'b0;
                queue_result(c);
                emitted++;
            end
        end
        if (emitted == 0) begin
            c = '0;
            c.empty = 1'b1;
            queue_result(c);
        end
        centroid_q[$].lst = 1'b1;
        pts_held = 0;
    endtask

    task automatic send_point(int x, int y, bit last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, COORD_W'(y), COORD_W'(x)};
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (pts_held < NPTS) begin
            pt_x[pts_held] = x;
            pt_y[pts_held] = y;
            pts_held++;
        end
        if (last) cluster_frame();
    endtask

    // Drain all results, then let the core settle before touching registers.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        while (centroid_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DAT_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_RADIUS: radius = val & 10'h3ff;
            REG_MINMEM: min_mem = val & 6'h3f;
            REG_R1X: pose_x[0] = val;
            REG_R1Y: pose_y[0] = val;
            REG_R2X: pose_x[1] = val;
            REG_R2Y: pose_y[1] = val;
            REG_R3X: pose_x[2] = val;
            REG_R3Y: pose_y[2] = val;
            default: ;
        endcase
    endtask

    task automatic set_poses(int ax, int ay, int bx, int by, int cx, int cy);
        write_reg(REG_R1X, ax); write_reg(REG_R1Y, ay);
        write_reg(REG_R2X, bx); write_reg(REG_R2Y, by);
        write_reg(REG_R3X, cx); write_reg(REG_R3Y, cy);
    endtask

    function automatic int clamp13(int v);
        return v > 4095 ? 4095 : (v < -4096 ? -4096 : v);
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = steady ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_centroid want;
        t_centroid got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cx = m_axis_tdata[12:0];
            got.cy = m_axis_tdata[25:13];
            got.cnt = m_axis_tdata[32:26];
            got.empty = m_axis_tuser;
            got.lst = m_axis_tlast;
            if (centroid_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %p", got);
            end else begin
                want = centroid_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("centroid mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    task automatic test_defaults();
        send_point(100, 100, 0);
        send_point(110, 95, 0);
        send_point(90, 105, 0);
        send_point(-4096, -4096, 0);
        send_point(4095, 4095, 1);
        send_point(-4096, 4095, 1);             // lone point: empty frame result
        send_point(4095, -4096, 0);
        send_point(4090, -4090, 0);
        send_point(4094, -4095, 1);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_RADIUS, 0);               // nothing can join
        send_point(5, 5, 0);
        send_point(5, 5, 1);
        wait_idle();
        write_reg(REG_RADIUS, 1023);
        write_reg(REG_MINMEM, 0);
        send_point(-1000, -1000, 0);
        send_point(-1500, -600, 0);
        send_point(3000, 3000, 1);
        wait_idle();
        write_reg(REG_MINMEM, 63);              // two points can never pass
        send_point(1, 1, 0);
        send_point(2, 2, 1);
        wait_idle();
        // teammates present: a seed next to one is skipped, absent poses ignored
        write_reg(REG_MINMEM, 0);
        write_reg(REG_RADIUS, 60);
        set_poses(4095, 4095, -4096, -4096, 0, 200);
        send_point(4050, 4050, 0);
        send_point(0, 150, 0);
        send_point(-4096, -4096, 0);
        send_point(0, 99, 1);
        wait_idle();
        set_poses(-4096, 4095, 4095, -4096, 0, 0);
        send_point(-4000, 4000, 0);
        send_point(4000, -4000, 1);
        wait_idle();
    endtask

    // Overflow the store with isolated points: every stored point is its own
    // cluster, so the frame also runs into the result cap.
    task automatic test_store_full();
        write_reg(REG_RADIUS, 10);
        write_reg(REG_MINMEM, 0);
        set_poses(0, 0, 0, 0, 0, 0);
        steady = 1'b1;
        for (int i = 0; i < NPTS + 2; i++)
            send_point(-3500 + (i % 8) * 900, -3500 + (i / 8) * 900, i == NPTS + 1);
        steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_random();
        int left;
        int npts;
        int cxr;
        int cyr;
        left = 42;
        while (left > 0) begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_RADIUS, $urandom_range(0, 1023));
                default: write_reg(REG_RADIUS, $urandom_range(20, 120));
            endcase
            write_reg(REG_MINMEM, $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                             : $urandom_range(0, 3));
            set_poses($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                      $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                      $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) hold_req = 1'b1;
            for (int f = 0; f < 3; f++) begin
                npts = $urandom_range(1, 9);
                cxr = $urandom_range(0, 8191) - 4096;
                cyr = $urandom_range(0, 8191) - 4096;
                for (int p = 0; p < npts; p++) begin
                    if ($urandom_range(0, 4) == 0)
                        send_point($urandom_range(0, 8191) - 4096,
                                   $urandom_range(0, 8191) - 4096, p == npts - 1);
                    else
                        send_point(clamp13(cxr + $urandom_range(0, 80) - 40),
                                   clamp13(cyr + $urandom_range(0, 80) - 40), p == npts - 1);
                    if ($urandom_range(0, 5) == 0) begin
                        cxr = $urandom_range(0, 8191) - 4096;
                        cyr = $urandom_range(0, 8191) - 4096;
                    end
                end
                left -= npts;
            end
            wait_idle();
            steady = 1'b0;
        end
    endtask

    initial begin
        pts_held = 0;
        radius = 50;
        min_mem = 2;
        foreach (pose_x[r]) begin
            pose_x[r] = 0;
            pose_y[r] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_config_extremes();
        test_store_full();
        hold_req = 1'b1;
        test_random();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && centroid_q.size() == 0)
            $display("[obstacle_point_clustering_core] OK");
        else
            $display("[obstacle_point_clustering_core] ERROR");
        $finish;
    end
endmodule

@@ obstacle_point_clustering_core.f @@
rtl/opc_pkg.sv
rtl/obstacle_point_clustering_core.sv
rtl/opc_checker.sv
bench/tb_top.sv
